// File: sv/a4star_min_image_distance_unit_defines.svh
// Assertion macros for the A4* minimum-image distance unit.
// Used by the top level only; needs a clk and rst_n in scope.
`ifndef A4STAR_MIN_IMAGE_DISTANCE_UNIT_DEFINES_SVH
`define A4STAR_MIN_IMAGE_DISTANCE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define A4MID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define A4MID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/a4mid_pkg.sv
// Types, constants and helpers for the A4* minimum-image distance unit.
// No dependencies.
`default_nettype none

package a4mid_pkg;

  localparam int NAX       = 4;   // lattice axes
  localparam int NIMG      = 3;   // images per axis
  localparam int DISP_W    = 8;
  localparam int EXT_W     = 7;
  localparam int CW        = 10;  // candidate coordinate, signed
  localparam int SW        = 23;  // signed working width of the form
  localparam int QW        = 21;  // unsigned width of the true minimum
  localparam int FW        = 17;  // form_min port width
  localparam int DW        = 16;  // dist_fixed port width
  localparam int FRAC_BITS = 8;
  localparam int SQ_W      = 40;  // square-root remainder width
  localparam int NXY       = NIMG * NIMG;
  localparam int NXYZ      = NXY * NIMG;

  localparam logic [FW-1:0] FORM_MAX = {FW{1'b1}};
  localparam logic [DW-1:0] DIST_MAX = {DW{1'b1}};
  // Minimum at or above this gives a distance of 2^DW or more
  localparam logic [QW-1:0] SAT_Q = QW'(5 * (1 << (2 * DW - 2 * FRAC_BITS)));

  // Register indexes of the configuration port
  localparam logic [1:0] REG_EXTENT_X = 2'd0;
  localparam logic [1:0] REG_EXTENT_Y = 2'd1;
  localparam logic [1:0] REG_EXTENT_Z = 2'd2;
  localparam logic [1:0] REG_EXTENT_T = 2'd3;

  typedef logic signed [DISP_W-1:0] disp_t;
  typedef logic [EXT_W-1:0]         ext_t;
  typedef logic signed [CW-1:0]     cand_t;
  typedef logic signed [SW-1:0]     work_t;
  typedef logic [QW-1:0]            form_t;

  function automatic work_t min3(input work_t a, input work_t b, input work_t c);
    work_t m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction

endpackage

`default_nettype wire

// File: sv/a4mid_form.sv
// Quadratic form over the 81 periodic images, built up axis by axis.
// Four stages; returns 27 partial minima (minimum already taken over t).
// Depends on a4mid_pkg.
`default_nettype none

module a4mid_form import a4mid_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  disp_t disp [NAX],
  input  ext_t  ext [NAX],
  output logic  out_valid,
  input  logic  out_stall,
  output work_t part [NXYZ]
);

  localparam int NST = 4;

  logic [NST-1:0] v_r;
  logic [NST:0]   en;

  cand_t cand_nxt [NAX][NIMG];
  cand_t cand_r   [NAX][NIMG];
  work_t a_nxt [NXY];
  work_t s_nxt [NXY];
  work_t a_r   [NXY];
  work_t s_r   [NXY];
  cand_t z1_r [NIMG];
  cand_t t1_r [NIMG];
  work_t p_nxt  [NXYZ];
  work_t s2_nxt [NXYZ];
  work_t p_r    [NXYZ];
  work_t s2_r   [NXYZ];
  cand_t t2_r [NIMG];
  work_t m_nxt [NXYZ];
  work_t m_r   [NXYZ];

  // Ready chain from the back
  always_comb begin
    en[NST] = !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end
  assign in_stall = !en[0];

  // Stage 0: three images of each axis
  always_comb begin
    cand_t b;
    cand_t e;
    for (int i = 0; i < NAX; i++) begin
      b = CW'(disp[i]);
      e = cand_t'({{(CW-EXT_W){1'b0}}, ext[i]});
      cand_nxt[i][0] = b - e;
      cand_nxt[i][1] = b;
      cand_nxt[i][2] = b + e;
    end
  end

  // Stage 1: x,y part of the form
  always_comb begin
    work_t x;
    work_t y;
    for (int a = 0; a < NIMG; a++) begin
      for (int b = 0; b < NIMG; b++) begin
        x = SW'(cand_r[0][a]);
        y = SW'(cand_r[1][b]);
        a_nxt[a*NIMG+b] = ((x * x) <<< 2) + ((y * y) <<< 2) - ((x * y) <<< 1);
        s_nxt[a*NIMG+b] = x + y;
      end
    end
  end

  // Stage 2: add z
  always_comb begin
    work_t z;
    for (int j = 0; j < NXY; j++) begin
      for (int c = 0; c < NIMG; c++) begin
        z = SW'(z1_r[c]);
        p_nxt[j*NIMG+c]  = a_r[j] + ((z * z) <<< 2) - ((s_r[j] * z) <<< 1);
        s2_nxt[j*NIMG+c] = s_r[j] + z;
      end
    end
  end

  // Stage 3: add t and keep the smallest of its three images
  always_comb begin
    work_t t;
    work_t q [NIMG];
    for (int m = 0; m < NXYZ; m++) begin
      for (int e = 0; e < NIMG; e++) begin
        t = SW'(t2_r[e]);
        q[e] = p_r[m] + ((t * t) <<< 2) - ((s2_r[m] * t) <<< 1);
      end
      m_nxt[m] = min3(q[0], q[1], q[2]);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      cand_r <= cand_nxt;
    end
    if (en[1] && v_r[0]) begin
      a_r  <= a_nxt;
      s_r  <= s_nxt;
      z1_r <= cand_r[2];
      t1_r <= cand_r[3];
    end
    if (en[2] && v_r[1]) begin
      p_r  <= p_nxt;
      s2_r <= s2_nxt;
      t2_r <= t1_r;
    end
    if (en[3] && v_r[2]) begin
      m_r <= m_nxt;
    end
  end

  assign out_valid = v_r[NST-1];
  assign part      = m_r;

endmodule

`default_nettype wire

// File: sv/a4mid_minred.sv
// Registered minimum tree, 27 to 9 to 3 to 1, then saturation of form_min.
// Depends on a4mid_pkg.
`default_nettype none

module a4mid_minred import a4mid_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  work_t         part [NXYZ],
  output logic          out_valid,
  input  logic          out_stall,
  output form_t         q_min,
  output logic [FW-1:0] form_min
);

  localparam int NST = 3;

  logic [NST-1:0] v_r;
  logic [NST:0]   en;

  work_t l1_r [NXY];
  work_t l2_r [NIMG];
  form_t q_r;
  logic [FW-1:0] f_r;
  work_t last;
  form_t q_nxt;

  always_comb begin
    en[NST] = !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end
  assign in_stall = !en[0];

  // Final minimum is never negative
  assign last  = min3(l2_r[0], l2_r[1], l2_r[2]);
  assign q_nxt = last[QW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      for (int j = 0; j < NXY; j++) begin
        l1_r[j] <= min3(part[3*j], part[3*j+1], part[3*j+2]);
      end
    end
    if (en[1] && v_r[0]) begin
      for (int j = 0; j < NIMG; j++) begin
        l2_r[j] <= min3(l1_r[3*j], l1_r[3*j+1], l1_r[3*j+2]);
      end
    end
    if (en[2] && v_r[1]) begin
      q_r <= q_nxt;
      f_r <= (q_nxt > form_t'(FORM_MAX)) ? FORM_MAX : q_nxt[FW-1:0];
    end
  end

  assign out_valid = v_r[NST-1];
  assign q_min     = q_r;
  assign form_min  = f_r;

endmodule

`default_nettype wire

// File: sv/a4mid_sqrt.sv
// Pipelined square root: largest d with 5*d^2 <= q * 2^(2*FRAC_BITS).
// One result bit per stage, DW stages. Depends on a4mid_pkg.
`default_nettype none

module a4mid_sqrt import a4mid_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  form_t         q_min,
  input  logic [FW-1:0] form_min,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [FW-1:0] form_out,
  output logic [DW-1:0] dist_out
);

  logic [DW-1:0] v_r;
  logic [DW:0]   en;

  logic [SQ_W-1:0] r_r   [DW];
  logic [DW-1:0]   d_r   [DW];
  logic [FW-1:0]   f_r   [DW];
  logic            sat_r [DW];

  always_comb begin
    en[DW] = !out_stall;
    for (int k = DW - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end
  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < DW; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  for (genvar g = 0; g < DW; g++) begin : g_step
    localparam int K = DW - 1 - g;
    logic [SQ_W-1:0] r_in;
    logic [DW-1:0]   d_in;
    logic [FW-1:0]   f_in;
    logic            sat_in;
    logic            v_in;
    logic [SQ_W-1:0] base;
    logic [SQ_W-1:0] trial;

    if (g == 0) begin : g_first
      assign r_in   = SQ_W'(q_min) << (2 * FRAC_BITS);
      assign d_in   = '0;
      assign f_in   = form_min;
      assign sat_in = (q_min >= SAT_Q);
      assign v_in   = in_valid;
    end else begin : g_next
      assign r_in   = r_r[g-1];
      assign d_in   = d_r[g-1];
      assign f_in   = f_r[g-1];
      assign sat_in = sat_r[g-1];
      assign v_in   = v_r[g-1];
    end

    // 5 * (2*d*2^K + 2^(2K)), the growth of 5*d^2 when bit K is set
    assign base  = (SQ_W'(d_in) << (K + 1)) + (SQ_W'(1) << (2 * K));
    assign trial = base + (base << 2);

    always_ff @(posedge clk) begin
      if (en[g] && v_in) begin
        f_r[g]   <= f_in;
        sat_r[g] <= sat_in;
        if (r_in >= trial) begin
          r_r[g] <= r_in - trial;
          d_r[g] <= d_in | (DW'(1) << K);
        end else begin
          r_r[g] <= r_in;
          d_r[g] <= d_in;
        end
      end
    end
  end

  assign out_valid = v_r[DW-1];
  assign form_out  = f_r[DW-1];
  assign dist_out  = sat_r[DW-1] ? DIST_MAX : d_r[DW-1];

endmodule

`default_nettype wire

// File: sv/a4star_min_image_distance_unit.sv
// A4* minimum-image distance unit.
//
// Input channel: in_valid/in_stall with a four-component displacement word.
// Output channel: out_valid/out_stall with the minimum form value over the
// 81 periodic images (five times the squared A4* distance, saturated) and
// the distance with eight fraction bits, floored and saturated.
// Config channel: cfg_valid/cfg_ready, always ready; cfg_index picks one of
// the four axis extents. Write only while the unit is empty.
// Form evaluation, then the minimum tree, then the square root, one result
// bit per stage. Throughput is one word per cycle when no stall holds it;
// every stage holds a valid bit. On stall, stages hold their words and
// empty stages keep filling, so input is taken until the pipeline is
// full. Reset empties the pipeline and sets every extent to 8.
// Depends on a4mid_pkg, a4mid_form, a4mid_minred, a4mid_sqrt and the
// defines header.
`default_nettype none
`include "a4star_min_image_distance_unit_defines.svh"

module a4star_min_image_distance_unit import a4mid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [7:0]    in_disp_x,
  input  logic signed [7:0]    in_disp_y,
  input  logic signed [7:0]    in_disp_z,
  input  logic signed [7:0]    in_disp_t,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [16:0]          out_form_min,
  output logic [15:0]          out_dist_fixed,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [6:0]           cfg_data
);

  ext_t  ext_r [NAX];
  disp_t disp [NAX];
  work_t part [NXYZ];
  logic  f_valid;
  logic  f_stall;
  logic  m_valid;
  logic  m_stall;
  form_t q_min;
  logic [FW-1:0] form_min;

  // Extent registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NAX; i++) ext_r[i] <= EXT_W'(8);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EXTENT_X: ext_r[0] <= cfg_data;
        REG_EXTENT_Y: ext_r[1] <= cfg_data;
        REG_EXTENT_Z: ext_r[2] <= cfg_data;
        REG_EXTENT_T: ext_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign disp[0] = in_disp_x;
  assign disp[1] = in_disp_y;
  assign disp[2] = in_disp_z;
  assign disp[3] = in_disp_t;

  a4mid_form u_form (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .disp      (disp),
    .ext       (ext_r),
    .out_valid (f_valid),
    .out_stall (f_stall),
    .part      (part)
  );

  a4mid_minred u_minred (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_stall  (f_stall),
    .part      (part),
    .out_valid (m_valid),
    .out_stall (m_stall),
    .q_min     (q_min),
    .form_min  (form_min)
  );

  a4mid_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid),
    .in_stall  (m_stall),
    .q_min     (q_min),
    .form_min  (form_min),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .form_out  (out_form_min),
    .dist_out  (out_dist_fixed)
  );

  // Zero distance exactly when the form is zero
  `A4MID_ASSERT_NOW(a_zero_match, out_valid, (out_form_min == '0) == (out_dist_fixed == '0), "form and distance disagree on zero")
  // A free output lets the whole pipeline move
  `A4MID_ASSERT_NOW(a_no_false_stall, !out_stall, !in_stall, "input stalled while output is free")
  // An empty pipeline gives no result next cycle
  `A4MID_ASSERT_NEXT(a_no_ghost, !f_valid && !m_valid && !out_valid && !in_valid && !u_sqrt.v_r[DW-2], !out_valid, "result without a word")

endmodule

`default_nettype wire
